>>> rtl/dhtq_pkg.sv
// ----------------------------------------------------------------------------
// dhtq_pkg
// Types and constants of the d-ary heap timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dhtq_pkg;

   localparam int TIMER_SLOTS = 64;
   localparam int ARITY       = 4;
   localparam int ID_W        = 6;
   localparam int TIME_W      = 64;
   localparam int BUDGET_W    = 7;
   localparam int STATUS_W    = 3;
   localparam int SLOT_W      = $clog2(TIMER_SLOTS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int K_W         = $clog2(ARITY + 1);
   localparam int CHILD_W     = SLOT_W + $clog2(ARITY) + 2;

   localparam logic [1:0] ACT_START  = 2'd0;
   localparam logic [1:0] ACT_CANCEL = 2'd1;
   localparam logic [1:0] ACT_EXPIRE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_STARTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ARMED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ARMED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd5;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [ID_W-1:0]   owner;
   } entry_type;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_CN_WAIT = 10'b00_0000_0010,
      S_UP_CHK  = 10'b00_0000_0100,
      S_UP_CMP  = 10'b00_0000_1000,
      S_DN_RD   = 10'b00_0001_0000,
      S_DN_CMP  = 10'b00_0010_0000,
      S_DN_END  = 10'b00_0100_0000,
      S_EX_CHK  = 10'b00_1000_0000,
      S_EX_WAIT = 10'b01_0000_0000,
      S_EX_EMIT = 10'b10_0000_0000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/dary_heap_timer_queue.sv
// ----------------------------------------------------------------------------
// dary_heap_timer_queue
// Timer queue on a 4-ary min-heap in block memory, with position table.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  request   req_action/timer_id/deadline/now_time/budget start & !busy
//  response  rsp_status/fired_id/earliest_deadline/last   rsp_valid, 1 cycle
//
//  Heap and position table sit in memories with registered reads; each level
//  of sift-up reads the parent, then compares and writes; each level of sift-down
//  reads and compares each child in turn, then writes (3 levels at 64 slots).
//  An expire gives one response per popped timer, or a single response
//  when nothing is due.
//  busy stays high until the last response of a request.
//  Reset is synchronous; it clears armed flags and the fill count, memories
//  need no clearing. The receiver cannot stall responses.
// ----------------------------------------------------------------------------
`default_nettype none

module dary_heap_timer_queue (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [1:0]                          req_action,
   input  wire  [dhtq_pkg::ID_W-1:0]           req_timer_id,
   input  wire  [dhtq_pkg::TIME_W-1:0]         req_deadline,
   input  wire  [dhtq_pkg::TIME_W-1:0]         req_now_time,
   input  wire  [dhtq_pkg::BUDGET_W-1:0]       req_budget,
   output logic                                rsp_valid,
   output logic [dhtq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [dhtq_pkg::ID_W-1:0]           rsp_fired_id,
   output logic [dhtq_pkg::TIME_W-1:0]         rsp_earliest_deadline,
   output logic                                rsp_last
);
   import dhtq_pkg::*;

   localparam int IDS = 1 << ID_W;

   entry_type heap_mem [TIMER_SLOTS];
   logic [SLOT_W-1:0] pos_mem [IDS];
   entry_type heap_q;
   logic [SLOT_W-1:0] pos_q;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [BUDGET_W-1:0] lim_ff, lim_in, n_ff, n_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0] i_ff, i_in, pick_ff, pick_in;
   entry_type mv_ff, mv_in, best_ff, best_in;
   logic [K_W-1:0] k_ff, k_in;
   logic found_ff, found_in, moved_ff, moved_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0] fired_ff, fired_in;
   entry_type top_ff, top_in;
   logic [IDS-1:0] armed_ff, armed_in;

   logic rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic pos_rd_en;
   logic wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type wr_data;

   logic [CHILD_W-1:0] child;
   logic [SLOT_W-1:0] parent;
   logic [CNT_W-1:0] count_m1;
   logic cont;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         heap_q <= heap_mem[rd_addr];
      end
      if (pos_rd_en) begin
         pos_q <= pos_mem[id_in];
      end
      if (wr_en) begin
         heap_mem[wr_addr]     <= wr_data;
         pos_mem[wr_data.owner] <= wr_addr;
      end
   end

   always_comb begin
      child    = CHILD_W'(i_ff) * CHILD_W'(ARITY) + CHILD_W'(k_ff);
      parent   = SLOT_W'((i_ff - SLOT_W'(1)) / ARITY);
      count_m1 = count_ff - CNT_W'(1);
      cont     = (BUDGET_W'(n_ff + BUDGET_W'(1)) < lim_ff) && (count_ff != '0)
                 && (top_ff.deadline <= now_ff);
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      id_in     = id_ff;
      now_in    = now_ff;
      lim_in    = lim_ff;
      n_in      = n_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      pick_in   = pick_ff;
      mv_in     = mv_ff;
      best_in   = best_ff;
      k_in      = k_ff;
      found_in  = found_ff;
      moved_in  = moved_ff;
      status_in = status_ff;
      fired_in  = fired_ff;
      armed_in  = armed_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      pos_rd_en = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = i_ff;
      wr_data   = mv_ff;
      rsp_valid = 1'b0;
      rsp_last  = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_action;
               id_in    = req_timer_id;
               fired_in = req_timer_id;
               now_in   = req_now_time;
               lim_in   = (req_budget > BUDGET_W'(TIMER_SLOTS)) ?
                          BUDGET_W'(TIMER_SLOTS) : req_budget;
               n_in     = '0;
               moved_in = 1'b0;
               case (req_action)
                  ACT_START: begin
                     if (armed_ff[req_timer_id] || count_ff == CNT_W'(TIMER_SLOTS)) begin
                        status_in = ST_ARMED;
                        state_in  = S_UP_CMP;
                        moved_in  = 1'b1;
                     end else begin
                        status_in = ST_STARTED;
                        mv_in     = '{deadline: req_deadline, owner: req_timer_id};
                        i_in      = count_ff[SLOT_W-1:0];
                        count_in  = count_ff + CNT_W'(1);
                        armed_in[req_timer_id] = 1'b1;
                        state_in  = S_UP_CHK;
                     end
                  end
                  ACT_CANCEL: begin
                     if (!armed_ff[req_timer_id] || count_ff == '0) begin
                        status_in = ST_NOT_ARMED;
                        state_in  = S_UP_CMP;
                        moved_in  = 1'b1;
                     end else begin
                        status_in = ST_CANCELLED;
                        armed_in[req_timer_id] = 1'b0;
                        count_in  = count_m1;
                        rd_en     = 1'b1;
                        rd_addr   = count_m1[SLOT_W-1:0];
                        pos_rd_en = 1'b1;
                        state_in  = S_CN_WAIT;
                     end
                  end
                  ACT_EXPIRE: begin
                     state_in = S_EX_CHK;
                  end
                  default: ;
               endcase
            end
         end
         S_CN_WAIT: begin
            if (CNT_W'(pos_q) < count_ff) begin
               mv_in    = heap_q;
               i_in     = pos_q;
               state_in = S_UP_CHK;
            end else begin
               moved_in = 1'b1;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CHK: begin
            if (i_ff == '0) begin
               wr_en = 1'b1;
               if (op_ff == ACT_CANCEL && !moved_ff) begin
                  k_in     = K_W'(1);
                  found_in = 1'b0;
                  best_in  = mv_ff;
                  state_in = S_DN_RD;
               end else begin
                  moved_in = 1'b1;
                  state_in = S_UP_CMP;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               moved_in = 1'b0;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            // the sift-up compare step below decides the next state
            state_in = S_IDLE;
         end
         S_DN_RD: begin
            if (child >= CHILD_W'(count_ff)) begin
               state_in = S_DN_END;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = child[SLOT_W-1:0];
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (heap_q.deadline < best_ff.deadline) begin
               best_in  = heap_q;
               pick_in  = child[SLOT_W-1:0];
               found_in = 1'b1;
            end
            if (k_ff == K_W'(ARITY)) begin
               state_in = S_DN_END;
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = S_DN_RD;
            end
         end
         S_DN_END: begin
            wr_en = 1'b1;
            if (found_ff) begin
               wr_data  = best_ff;
               i_in     = pick_ff;
               k_in     = K_W'(1);
               found_in = 1'b0;
               best_in  = mv_ff;
               state_in = S_DN_RD;
            end else begin
               moved_in = 1'b1;
               state_in = (op_ff == ACT_EXPIRE) ? S_EX_EMIT : S_UP_CMP;
            end
         end
         S_EX_CHK: begin
            if (n_ff < lim_ff && count_ff != '0 && top_ff.deadline <= now_ff) begin
               fired_in = top_ff.owner;
               armed_in[top_ff.owner] = 1'b0;
               count_in = count_m1;
               if (count_m1 != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = count_m1[SLOT_W-1:0];
                  state_in = S_EX_WAIT;
               end else begin
                  state_in = S_EX_EMIT;
               end
            end else begin
               status_in = ST_NONE_DUE;
               fired_in  = '0;
               moved_in  = 1'b1;
               state_in  = S_UP_CMP;
            end
         end
         S_EX_WAIT: begin
            mv_in    = heap_q;
            best_in  = heap_q;
            i_in     = '0;
            k_in     = K_W'(1);
            found_in = 1'b0;
            state_in = S_DN_RD;
         end
         S_EX_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = !cont;
            n_in      = n_ff + BUDGET_W'(1);
            state_in  = cont ? S_EX_CHK : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // sift-up compare step, shared state with the final response cycle
      if (state_ff == S_UP_CMP) begin
         if (moved_ff) begin
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
            state_in  = S_IDLE;
         end else if (mv_ff.deadline < heap_q.deadline) begin
            wr_en    = 1'b1;
            wr_data  = heap_q;
            i_in     = parent;
            moved_in = 1'b0;
            found_in = 1'b1;
            state_in = S_UP_CHK;
         end else begin
            wr_en = 1'b1;
            if (op_ff == ACT_CANCEL && !found_ff) begin
               k_in     = K_W'(1);
               found_in = 1'b0;
               best_in  = mv_ff;
               state_in = S_DN_RD;
            end else begin
               moved_in = 1'b1;
               state_in = S_UP_CMP;
            end
         end
      end

      if (state_ff == S_UP_CHK && i_ff == '0 && op_ff == ACT_CANCEL && found_ff) begin
         k_in     = k_ff;
         best_in  = best_ff;
         moved_in = 1'b1;
         state_in = S_UP_CMP;
      end

      top_in = top_ff;
      if (wr_en && wr_addr == '0) begin
         top_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         armed_ff <= '0;
         moved_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         armed_ff <= armed_in;
         moved_ff <= moved_in;
         // found doubles as "sift-up moved" until the sift-down starts
         found_ff <= (state_ff == S_IDLE || state_ff == S_CN_WAIT) ? 1'b0 : found_in;
      end
      op_ff     <= op_in;
      id_ff     <= id_in;
      now_ff    <= now_in;
      lim_ff    <= lim_in;
      n_ff      <= n_in;
      i_ff      <= i_in;
      pick_ff   <= pick_in;
      mv_ff     <= mv_in;
      best_ff   <= best_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      fired_ff  <= fired_in;
      top_ff    <= top_in;
   end

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_status            = (state_ff == S_EX_EMIT) ? ST_EXPIRED : status_ff;
   assign rsp_fired_id          = fired_ff;
   assign rsp_earliest_deadline = (count_ff == '0) ? '0 : top_ff.deadline;

endmodule

`default_nettype wire
